// ----- sv/plbsc_pkg.sv -----
// ----------------------------------------------------------------------------
// plbsc_pkg: shared types and codes of the LED blink state classifier
// Input item codes, mode codes, configuration layout and the level
// classification helpers.
// ----------------------------------------------------------------------------
package plbsc_pkg;

	localparam int unsigned FUNC_W   = 2;
	localparam int unsigned MODE_W   = 3;
	localparam int unsigned COUNT_W  = 8;
	localparam int unsigned MS_W     = 16;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	// input item codes
	localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_LED0 = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_LED1 = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_INIT = 2'd3;

	// mode codes
	localparam logic [MODE_W-1:0] MODE_OFF       = 3'd0;
	localparam logic [MODE_W-1:0] MODE_AF        = 3'd1;
	localparam logic [MODE_W-1:0] MODE_AT        = 3'd2;
	localparam logic [MODE_W-1:0] MODE_FAIL      = 3'd3;
	localparam logic [MODE_W-1:0] MODE_UNMATCHED = 3'd4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BLINK_MIN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLINK_MAX = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FAIL_CNT  = 2'd2;

	localparam logic [MS_W-1:0]    BLINK_MIN_RST = 16'd500;
	localparam logic [MS_W-1:0]    BLINK_MAX_RST = 16'd525;
	localparam logic [COUNT_W-1:0] FAIL_CNT_RST  = 8'd4;
	localparam logic [COUNT_W-1:0] COUNT_MAX     = 8'hFF;

	typedef logic [FUNC_W-1:0]  func_t;
	typedef logic [MODE_W-1:0]  mode_t;
	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [MS_W-1:0]    ms_t;

	typedef struct packed {
		ms_t    blink_min;
		ms_t    blink_max;
		count_t blinks_to_fail;
	} cfg_t;

	// both on gives AT, only LED0 on gives AF; pins are active low
	function automatic mode_t classify(input logic p0, input logic p1);
		mode_t m;
		if (!p0 && !p1) begin
			m = MODE_AT;
		end else if (!p0) begin
			m = MODE_AF;
		end else begin
			m = MODE_OFF;
		end
		return m;
	endfunction

	function automatic mode_t init_mode(input mode_t m, input logic p0, input logic p1);
		mode_t r;
		if (m == MODE_OFF || m == MODE_FAIL) begin
			r = classify(p0, p1);
		end else begin
			r = MODE_UNMATCHED;
		end
		return r;
	endfunction

	function automatic mode_t static_mode(input mode_t m, input logic p0, input logic p1);
		mode_t r;
		if (m == MODE_FAIL) begin
			r = m;
		end else begin
			r = classify(p0, p1);
		end
		return r;
	endfunction

endpackage

// ----- sv/plbsc_if.sv -----
// ----------------------------------------------------------------------------
// plbsc_in_if / plbsc_out_if: item channels of the classifier
// Valid/ready channels carrying the input item and the result item.
// ----------------------------------------------------------------------------
interface plbsc_in_if;
	import plbsc_pkg::*;

	logic  valid;
	logic  ready;
	func_t func;
	logic  led0_pin;
	logic  led1_pin;

	modport source (output valid, output func, output led0_pin, output led1_pin,
		input ready);
	modport sink (input valid, input func, input led0_pin, input led1_pin,
		output ready);
endinterface

interface plbsc_out_if;
	import plbsc_pkg::*;

	logic   valid;
	logic   ready;
	mode_t  mode;
	count_t blinks;

	modport source (output valid, output mode, output blinks, input ready);
	modport sink (input valid, input mode, input blinks, output ready);
endinterface

// ----- sv/poe_led_blink_state_classifier_unit.sv -----
// ----------------------------------------------------------------------------
// poe_led_blink_state_classifier_unit: PoE power class from LED blink states
// Classifies a powered device from two active-low LED pins, counts LED0
// blinks and enters failure at the configured blink count.
// ----------------------------------------------------------------------------
//  channel     dir  handshake      payload
//  item_in     in   valid/ready    func, led0_pin, led1_pin
//  result_out  out  valid/ready    mode, blinks
//  cfg_*       in   write enable   cfg_idx, cfg_wdata
//
//  Item to result: input register, then result register.
//  One item per cycle while results are taken; state update is in between.
//  A stalled result holds the pipeline; the input register still fills.
//  Reset leaves mode off, blink count zero and the edge timer saturated.
// ----------------------------------------------------------------------------
module poe_led_blink_state_classifier_unit #(
	parameter int unsigned TIME_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	plbsc_in_if.sink                            item_in,
	plbsc_out_if.source                         result_out,
	input  logic                                cfg_wen,
	input  logic [plbsc_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [plbsc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import plbsc_pkg::*;

	cfg_t                  cfg;
	logic                  valid_s1;
	func_t                 func_s1;
	logic                  p0_s1;
	logic                  p1_s1;
	logic                  out_valid_q;
	mode_t                 mode_q;
	count_t                count_q;
	logic [TIME_WIDTH-1:0] since_q;
	mode_t                 mode_nxt;
	count_t                count_nxt;
	logic [TIME_WIDTH-1:0] since_nxt;
	logic                  advance;

	plbsc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	plbsc_step #(.TIME_WIDTH(TIME_WIDTH)) u_step (
		.cfg       (cfg),
		.func      (func_s1),
		.p0        (p0_s1),
		.p1        (p1_s1),
		.mode      (mode_q),
		.count     (count_q),
		.since     (since_q),
		.mode_nxt  (mode_nxt),
		.count_nxt (count_nxt),
		.since_nxt (since_nxt)
	);

	// the item in stage 1 moves on when the result register is free
	assign advance       = valid_s1 && (!out_valid_q || result_out.ready);
	assign item_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_in.ready) begin
			valid_s1 <= item_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_in.ready && item_in.valid) begin
			func_s1 <= item_in.func;
			p0_s1   <= item_in.led0_pin;
			p1_s1   <= item_in.led1_pin;
		end
	end

	// mode and blink count double as the result payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			mode_q      <= MODE_OFF;
			count_q     <= '0;
			since_q     <= '1;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				mode_q      <= mode_nxt;
				count_q     <= count_nxt;
				since_q     <= since_nxt;
			end else if (result_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_out.valid  = out_valid_q;
	assign result_out.mode   = mode_q;
	assign result_out.blinks = count_q;

endmodule

// ----- sv/plbsc_cfg.sv -----
// ----------------------------------------------------------------------------
// plbsc_cfg: configuration registers
// Blink window bounds and fail count, written through a plain write port.
// ----------------------------------------------------------------------------
module plbsc_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wen,
	input  logic [plbsc_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [plbsc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	output plbsc_pkg::cfg_t                     cfg
);
	import plbsc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.blink_min      <= BLINK_MIN_RST;
			cfg_q.blink_max      <= BLINK_MAX_RST;
			cfg_q.blinks_to_fail <= FAIL_CNT_RST;
		end else if (cfg_wen) begin
			case (cfg_idx)
				REG_BLINK_MIN: cfg_q.blink_min      <= cfg_wdata[MS_W-1:0];
				REG_BLINK_MAX: cfg_q.blink_max      <= cfg_wdata[MS_W-1:0];
				REG_FAIL_CNT:  cfg_q.blinks_to_fail <= cfg_wdata[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- sv/plbsc_step.sv -----
// ----------------------------------------------------------------------------
// plbsc_step: next-state logic for one item
// Applies a tick, LED edge or init request to mode, blink count and the
// time since the last LED0 edge.
// ----------------------------------------------------------------------------
module plbsc_step #(
	parameter int unsigned TIME_WIDTH = 16
) (
	input  plbsc_pkg::cfg_t          cfg,
	input  plbsc_pkg::func_t         func,
	input  logic                     p0,
	input  logic                     p1,
	input  plbsc_pkg::mode_t         mode,
	input  plbsc_pkg::count_t        count,
	input  logic [TIME_WIDTH-1:0]    since,
	output plbsc_pkg::mode_t         mode_nxt,
	output plbsc_pkg::count_t        count_nxt,
	output logic [TIME_WIDTH-1:0]    since_nxt
);
	import plbsc_pkg::*;

	// compare width covers both the timer and the 16-bit bounds
	localparam int unsigned CMP_W = (TIME_WIDTH > MS_W) ? TIME_WIDTH : MS_W;

	logic [CMP_W-1:0] since_x;
	logic [CMP_W-1:0] min_x;
	logic [CMP_W-1:0] max_x;
	logic             in_win;
	count_t           count_inc;
	mode_t            mode_edge;

	assign since_x   = CMP_W'(since);
	assign min_x     = CMP_W'(cfg.blink_min);
	assign max_x     = CMP_W'(cfg.blink_max);
	assign in_win    = (since_x > min_x) && (since_x < max_x);
	assign count_inc = (count == COUNT_MAX) ? count : count + COUNT_W'(1);

	always_comb begin
		mode_nxt  = mode;
		count_nxt = count;
		since_nxt = since;
		mode_edge = mode;
		case (func)
			FUNC_TICK: begin
				if (since != '1) begin
					since_nxt = since + TIME_WIDTH'(1);
				end
			end
			FUNC_LED0: begin
				if (in_win) begin
					count_nxt = count_inc;
					if (count_inc >= cfg.blinks_to_fail) begin
						mode_edge = MODE_FAIL;
					end
				end else begin
					// out-of-window edge after enough blinks re-runs init
					if (count >= cfg.blinks_to_fail) begin
						mode_edge = init_mode(mode, p0, p1);
					end
					count_nxt = '0;
				end
				since_nxt = '0;
				mode_nxt  = static_mode(mode_edge, p0, p1);
			end
			FUNC_LED1: begin
				mode_nxt = static_mode(mode, p0, p1);
			end
			FUNC_INIT: begin
				mode_nxt = init_mode(mode, p0, p1);
			end
			default: ;
		endcase
	end

endmodule
